### rtl/dtr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Depth-tested rasterizer package
// Shared screen constants, field types and the divider request/response.
// ----------------------------------------------------------------------------
package dtr_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int NPIX          = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(NPIX);
    localparam int DEPTH_W       = 32;
    localparam int COL_W         = 24;
    localparam int CNT_W         = 16;
    localparam int NUM_W         = 48;
    localparam int DEN_W         = 24;
    localparam int MUL_W         = 27;

    typedef enum logic [1:0] {
        REQ_DRAW  = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    typedef logic signed [15:0]        t_pos;
    typedef logic signed [16:0]        t_dlt;
    typedef logic signed [17:0]        t_crd;
    typedef logic signed [25:0]        t_z;
    typedef logic signed [MUL_W-1:0]   t_mul;
    typedef logic signed [2*MUL_W-1:0] t_prod;
    typedef logic [ADDR_W-1:0]         t_addr;
    typedef logic signed [NUM_W-1:0]   t_num;
    typedef logic [DEN_W-1:0]          t_den;

    typedef struct packed {
        logic start;
        logic round;
        t_num num;
        t_den den;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_num quo;
    } t_div_rsp;

endpackage
`default_nettype wire

### rtl/depth_tested_triangle_rasterizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Depth-tested triangle rasterizer
// Scanline triangle fill plus edge pass against a screen-sized depth and
// colour store, with clear and pixel read requests.
// ----------------------------------------------------------------------------
// One request is worked at a time; the result sits in an output register so
// the next request is taken while it waits. After reset the block sweeps
// both stores to zero, one pixel a cycle (all SCREEN_WIDTH*SCREEN_HEIGHT
// pixels, 76800 at 320x240), before it takes a request; a clear request
// sweeps the depth store the same way. A draw is bound by one shared
// divider: each drawn row needs its two boundary interpolations, each span
// pixel a depth step plus inverse depth, then a read-modify-write of the
// depth store, and each edge pixel its coordinate steps on top of those;
// off-screen pixels skip the inverse depth and the store access.
// ----------------------------------------------------------------------------
module depth_tested_triangle_rasterizer_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_req_type,
    input  logic signed [15:0]           i_v0_x,
    input  logic signed [15:0]           i_v0_y,
    input  logic [23:0]                  i_v0_depth,
    input  logic signed [15:0]           i_v1_x,
    input  logic signed [15:0]           i_v1_y,
    input  logic [23:0]                  i_v1_depth,
    input  logic signed [15:0]           i_v2_x,
    input  logic signed [15:0]           i_v2_y,
    input  logic [23:0]                  i_v2_depth,
    input  logic [23:0]                  i_fill_colour,
    input  logic [16:0]                  i_read_pixel_index,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [dtr_pkg::CNT_W-1:0]    o_pixels_written,
    output logic [dtr_pkg::COL_W-1:0]    o_pixel_colour,
    output logic [dtr_pkg::DEPTH_W-1:0]  o_pixel_inverse_depth
);
    import dtr_pkg::*;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_SETUP, S_ROW, S_M1, S_M2, S_XS, S_XW, S_M3, S_ZS, S_ZW,
        S_SPINIT, S_SPAN, S_EINIT, S_EDGE, S_PLOT, S_IW, S_RD, S_CMP, S_RREQ,
        S_RDAT, S_DONE
    } t_state;

    typedef enum logic [1:0] {C_LONG, C_SHORT, C_SPAN, C_EDGE} t_ctx;

    function automatic t_pos pick_pos(input logic [1:0] s, input t_pos p0, p1, p2);
        t_pos r;
        unique case (s)
            2'd0:    r = p0;
            2'd1:    r = p1;
            default: r = p2;
        endcase
        return r;
    endfunction

    function automatic t_z pick_z(input logic [1:0] s, input t_z p0, p1, p2);
        t_z r;
        unique case (s)
            2'd0:    r = p0;
            2'd1:    r = p1;
            default: r = p2;
        endcase
        return r;
    endfunction

    function automatic t_crd rdiv16(input logic signed [19:0] v);
        logic [19:0] m;
        logic [19:0] q;
        m = v[19] ? 20'(-v) : 20'(v);
        q = (m + 20'd8) >> 4;
        return v[19] ? t_crd'(-$signed(q)) : t_crd'($signed(q));
    endfunction

    t_state r_state;
    t_ctx   r_ctx;
    logic   r_part, r_comp;
    logic [1:0]  r_e;
    logic [17:0] r_t;
    logic [16:0] r_s, r_sn, r_en;
    logic        r_sneg;
    t_pos r_x0, r_x1, r_x2, r_y0, r_y1, r_y2;
    t_z   r_z0, r_z1, r_z2;
    t_pos r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    t_z   r_az, r_bz, r_cz;
    logic [COL_W-1:0] r_colour;
    t_crd r_xl, r_xs, r_px, r_py;
    t_z   r_zl, r_zs, r_pz, r_sdz, r_fz, r_edz;
    t_pos r_fx, r_fy;
    t_dlt r_edx, r_edy;
    t_prod r_prod, r_acc;
    t_addr r_idx, r_caddr;
    logic [DEPTH_W-1:0] r_inv;
    logic [CNT_W-1:0]   r_cnt;
    logic r_clr_col, r_clr_req, r_ov;
    logic [CNT_W-1:0]   r_out_cnt;
    logic [COL_W-1:0]   r_out_col, r_res_col;
    logic [DEPTH_W-1:0] r_out_inv, r_res_inv;

    t_dlt dx01, dy01, dx02, dy02, dx12, dy12;
    t_z   dz01, dz02, dz12;
    logic [1:0] sa, sb, sc, fi, ti;
    t_pos e_fx, e_fy, e_tx, e_ty;
    t_z   e_fz, e_tz;
    t_dlt e_dx, e_dy;
    logic [16:0] e_adx, e_ady;
    logic [15:0] row_lim;
    logic        row_go, row_in;
    t_pos        row_base;
    logic signed [19:0] row_v;
    t_crd        row_py;
    logic signed [18:0] sp_d;
    logic        plot_in, z_pos, pass;
    t_addr       n_idx;
    t_pos        op_x0;
    logic [16:0] op_dy;
    t_dlt        op_dx;
    t_z          op_dz, op_z0;
    logic [17:0] op_prm;
    t_mul        mul_a, mul_b;
    t_div_req    div_req;
    t_div_rsp    div_rsp;
    logic        dep_we, col_we, mem_re;
    t_addr       dep_waddr;
    logic [DEPTH_W-1:0] dep_wdata, dep_rdata;
    logic [COL_W-1:0]   col_wdata, col_rdata;

    assign dx01 = t_dlt'(r_bx) - t_dlt'(r_ax);
    assign dy01 = t_dlt'(r_by) - t_dlt'(r_ay);
    assign dz01 = r_bz - r_az;
    assign dx02 = t_dlt'(r_cx) - t_dlt'(r_ax);
    assign dy02 = t_dlt'(r_cy) - t_dlt'(r_ay);
    assign dz02 = r_cz - r_az;
    assign dx12 = t_dlt'(r_cx) - t_dlt'(r_bx);
    assign dy12 = t_dlt'(r_cy) - t_dlt'(r_by);
    assign dz12 = r_cz - r_bz;

    always_comb begin
        if (r_y0 <= r_y1 && r_y0 <= r_y2) begin
            sa = 2'd0;
            sb = (r_y1 <= r_y2) ? 2'd1 : 2'd2;
        end else if (r_y1 <= r_y0 && r_y1 <= r_y2) begin
            sa = 2'd1;
            sb = (r_y0 <= r_y2) ? 2'd0 : 2'd2;
        end else begin
            sa = 2'd2;
            sb = (r_y0 <= r_y1) ? 2'd0 : 2'd1;
        end
        sc = 2'd3 - sa - sb;
    end

    assign fi    = (r_e == 2'd2) ? 2'd1 : 2'd0;
    assign ti    = (r_e == 2'd0) ? 2'd1 : 2'd2;
    assign e_fx  = pick_pos(fi, r_x0, r_x1, r_x2);
    assign e_fy  = pick_pos(fi, r_y0, r_y1, r_y2);
    assign e_fz  = pick_z(fi, r_z0, r_z1, r_z2);
    assign e_tx  = pick_pos(ti, r_x0, r_x1, r_x2);
    assign e_ty  = pick_pos(ti, r_y0, r_y1, r_y2);
    assign e_tz  = pick_z(ti, r_z0, r_z1, r_z2);
    assign e_dx  = t_dlt'(e_tx) - t_dlt'(e_fx);
    assign e_dy  = t_dlt'(e_ty) - t_dlt'(e_fy);
    assign e_adx = e_dx[16] ? 17'(-e_dx) : 17'(e_dx);
    assign e_ady = e_dy[16] ? 17'(-e_dy) : 17'(e_dy);

    assign row_lim  = r_part ? dy12[15:0] : dy01[15:0];
    assign row_go   = r_t < {2'b0, row_lim};
    assign row_base = r_part ? r_by : r_ay;
    assign row_v    = 20'(row_base) + 20'(r_t);
    assign row_py   = rdiv16(row_v);
    assign row_in   = !row_py[17] && (row_py[16:0] < 17'(SCREEN_HEIGHT));

    assign sp_d = 19'(r_xs) - 19'(r_xl);

    assign plot_in = !r_px[17] && !r_py[17] && (r_px[16:0] < 17'(SCREEN_WIDTH))
                     && (r_py[16:0] < 17'(SCREEN_HEIGHT));
    assign z_pos   = r_pz > 0;
    assign n_idx   = t_addr'(r_py[16:0]) * t_addr'(SCREEN_WIDTH) + t_addr'(r_px[16:0]);
    assign pass    = r_inv > dep_rdata;

    always_comb begin
        op_x0  = '0;
        op_dx  = '0;
        op_dy  = r_sn;
        op_dz  = r_sdz;
        op_z0  = r_zl;
        op_prm = {1'b0, r_s};
        unique case (r_ctx)
            C_LONG: begin
                op_x0  = r_ax;
                op_dy  = 17'(dy02);
                op_dx  = dx02;
                op_dz  = dz02;
                op_z0  = r_az;
                op_prm = r_part ? (18'(dy01[15:0]) + r_t) : r_t;
            end
            C_SHORT: begin
                op_x0  = r_part ? r_bx : r_ax;
                op_dy  = r_part ? 17'(dy12) : 17'(dy01);
                op_dx  = r_part ? dx12 : dx01;
                op_dz  = r_part ? dz12 : dz01;
                op_z0  = r_part ? r_bz : r_az;
                op_prm = r_t;
            end
            C_EDGE: begin
                op_x0  = r_comp ? r_fy : r_fx;
                op_dy  = r_en;
                op_dx  = r_comp ? r_edy : r_edx;
                op_dz  = r_edz;
                op_z0  = r_fz;
                op_prm = r_t;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mul_a = (r_state == S_M1) ? t_mul'(op_x0) : t_mul'({1'b0, op_prm});
        if (r_state == S_M1) begin
            mul_b = t_mul'({1'b0, op_dy});
        end else if (r_state == S_M2) begin
            mul_b = t_mul'(op_dx);
        end else begin
            mul_b = t_mul'(op_dz);
        end
    end

    always_comb begin
        div_req = '0;
        if (r_state == S_XS) begin
            div_req.start = 1'b1;
            div_req.round = 1'b1;
            div_req.num   = t_num'(r_acc + r_prod);
            div_req.den   = DEN_W'({op_dy, 4'b0});
        end else if (r_state == S_ZS) begin
            div_req.start = 1'b1;
            div_req.num   = t_num'(r_prod);
            div_req.den   = DEN_W'(op_dy);
        end else if (r_state == S_PLOT && plot_in && z_pos) begin
            div_req.start = 1'b1;
            div_req.num   = t_num'({DEPTH_W{1'b1}});
            div_req.den   = DEN_W'(r_pz);
        end
    end

    dtr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign dep_we    = (r_state == S_CLR) || (r_state == S_CMP && pass);
    assign col_we    = (r_state == S_CLR && r_clr_col) || (r_state == S_CMP && pass);
    assign dep_waddr = (r_state == S_CLR) ? r_caddr : r_idx;
    assign dep_wdata = (r_state == S_CLR) ? '0 : r_inv;
    assign col_wdata = (r_state == S_CLR) ? '0 : r_colour;
    assign mem_re    = (r_state == S_RD) || (r_state == S_RREQ);

    dtr_ram #(.WIDTH(DEPTH_W), .DEPTH(NPIX)) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (dep_we),
        .i_waddr (dep_waddr),
        .i_wdata (dep_wdata),
        .i_re    (mem_re),
        .i_raddr (r_idx),
        .o_rdata (dep_rdata)
    );

    dtr_ram #(.WIDTH(COL_W), .DEPTH(NPIX)) u_colour_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (dep_waddr),
        .i_wdata (col_wdata),
        .i_re    (mem_re),
        .i_raddr (r_idx),
        .o_rdata (col_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_ctx     <= C_LONG;
            r_caddr   <= '0;
            r_clr_col <= 1'b1;
            r_clr_req <= 1'b0;
            r_ov      <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (r_state == S_DONE && (!r_ov || i_ready)) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_caddr <= r_caddr + 1'b1;
                    if (r_caddr == t_addr'(NPIX - 1)) begin
                        r_clr_col <= 1'b0;
                        r_state   <= r_clr_req ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cnt     <= '0;
                        r_res_col <= '0;
                        r_res_inv <= '0;
                        r_x0 <= i_v0_x;
                        r_y0 <= i_v0_y;
                        r_z0 <= t_z'({2'b0, i_v0_depth});
                        r_x1 <= i_v1_x;
                        r_y1 <= i_v1_y;
                        r_z1 <= t_z'({2'b0, i_v1_depth});
                        r_x2 <= i_v2_x;
                        r_y2 <= i_v2_y;
                        r_z2 <= t_z'({2'b0, i_v2_depth});
                        r_colour <= i_fill_colour;
                        r_idx    <= t_addr'(i_read_pixel_index);
                        unique case (t_req'(i_req_type))
                            REQ_DRAW:  r_state <= S_SETUP;
                            REQ_CLEAR: begin
                                r_caddr   <= '0;
                                r_clr_req <= 1'b1;
                                r_state   <= S_CLR;
                            end
                            REQ_READ: begin
                                r_state <= (32'(i_read_pixel_index) < 32'(NPIX))
                                           ? S_RREQ : S_DONE;
                            end
                            default:   r_state <= S_DONE;
                        endcase
                    end
                end
                S_SETUP: begin
                    r_ax <= pick_pos(sa, r_x0, r_x1, r_x2);
                    r_ay <= pick_pos(sa, r_y0, r_y1, r_y2);
                    r_az <= pick_z(sa, r_z0, r_z1, r_z2);
                    r_bx <= pick_pos(sb, r_x0, r_x1, r_x2);
                    r_by <= pick_pos(sb, r_y0, r_y1, r_y2);
                    r_bz <= pick_z(sb, r_z0, r_z1, r_z2);
                    r_cx <= pick_pos(sc, r_x0, r_x1, r_x2);
                    r_cy <= pick_pos(sc, r_y0, r_y1, r_y2);
                    r_cz <= pick_z(sc, r_z0, r_z1, r_z2);
                    r_part  <= 1'b0;
                    r_t     <= '0;
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    if (row_go) begin
                        if (row_in) begin
                            r_py    <= row_py;
                            r_ctx   <= C_LONG;
                            r_state <= S_M1;
                        end else begin
                            r_t <= r_t + 18'd16;
                        end
                    end else if (!r_part) begin
                        r_part <= 1'b1;
                        r_t    <= '0;
                    end else begin
                        r_e     <= '0;
                        r_state <= S_EINIT;
                    end
                end
                S_M1: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_acc   <= r_prod;
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_XS;
                end
                S_XS: r_state <= S_XW;
                S_XW: begin
                    if (div_rsp.done) begin
                        unique case (r_ctx)
                            C_LONG: begin
                                r_xl    <= t_crd'(div_rsp.quo);
                                r_state <= S_M3;
                            end
                            C_SHORT: begin
                                r_xs    <= t_crd'(div_rsp.quo);
                                r_state <= S_M3;
                            end
                            default: begin
                                if (!r_comp) begin
                                    r_px    <= t_crd'(div_rsp.quo);
                                    r_comp  <= 1'b1;
                                    r_state <= S_M1;
                                end else begin
                                    r_py    <= t_crd'(div_rsp.quo);
                                    r_state <= S_M3;
                                end
                            end
                        endcase
                    end
                end
                S_M3: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_ZS;
                end
                S_ZS: r_state <= S_ZW;
                S_ZW: begin
                    if (div_rsp.done) begin
                        unique case (r_ctx)
                            C_LONG: begin
                                r_zl    <= op_z0 + t_z'(div_rsp.quo);
                                r_ctx   <= C_SHORT;
                                r_state <= S_M1;
                            end
                            C_SHORT: begin
                                r_zs    <= op_z0 + t_z'(div_rsp.quo);
                                r_state <= S_SPINIT;
                            end
                            default: begin
                                r_pz    <= op_z0 + t_z'(div_rsp.quo);
                                r_state <= S_PLOT;
                            end
                        endcase
                    end
                end
                S_SPINIT: begin
                    r_sneg  <= sp_d[18];
                    r_sn    <= sp_d[18] ? 17'(-sp_d) : 17'(sp_d);
                    r_sdz   <= r_zs - r_zl;
                    r_s     <= '0;
                    r_state <= S_SPAN;
                end
                S_SPAN: begin
                    if (r_s < r_sn) begin
                        r_px    <= r_sneg ? (r_xl - t_crd'({1'b0, r_s}))
                                          : (r_xl + t_crd'({1'b0, r_s}));
                        r_ctx   <= C_SPAN;
                        r_state <= S_M3;
                    end else begin
                        r_t     <= r_t + 18'd16;
                        r_state <= S_ROW;
                    end
                end
                S_EINIT: begin
                    if (r_e == 2'd3) begin
                        r_state <= S_DONE;
                    end else begin
                        r_fx    <= e_fx;
                        r_fy    <= e_fy;
                        r_fz    <= e_fz;
                        r_edx   <= e_dx;
                        r_edy   <= e_dy;
                        r_edz   <= e_tz - e_fz;
                        r_en    <= (e_adx > e_ady) ? e_adx : e_ady;
                        r_t     <= '0;
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    if (r_t < {1'b0, r_en}) begin
                        r_ctx   <= C_EDGE;
                        r_comp  <= 1'b0;
                        r_state <= S_M1;
                    end else begin
                        r_e     <= r_e + 1'b1;
                        r_state <= S_EINIT;
                    end
                end
                S_PLOT: begin
                    if (!plot_in) begin
                        if (r_ctx == C_SPAN) begin
                            r_s     <= r_s + 1'b1;
                            r_state <= S_SPAN;
                        end else begin
                            r_t     <= r_t + 18'd16;
                            r_state <= S_EDGE;
                        end
                    end else begin
                        r_idx <= n_idx;
                        if (z_pos) begin
                            r_state <= S_IW;
                        end else begin
                            r_inv   <= '1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_IW: begin
                    if (div_rsp.done) begin
                        r_inv   <= div_rsp.quo[DEPTH_W-1:0];
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_CMP;
                S_CMP: begin
                    if (pass && r_cnt != '1) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_ctx == C_SPAN) begin
                        r_s     <= r_s + 1'b1;
                        r_state <= S_SPAN;
                    end else begin
                        r_t     <= r_t + 18'd16;
                        r_state <= S_EDGE;
                    end
                end
                S_RREQ: r_state <= S_RDAT;
                S_RDAT: begin
                    r_res_col <= col_rdata;
                    r_res_inv <= dep_rdata;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ov || i_ready) begin
                        r_out_cnt <= r_cnt;
                        r_out_col <= r_res_col;
                        r_out_inv <= r_res_inv;
                        r_clr_req <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready               = (r_state == S_IDLE);
    assign o_valid               = r_ov;
    assign o_pixels_written      = r_out_cnt;
    assign o_pixel_colour        = r_out_col;
    assign o_pixel_inverse_depth = r_out_inv;

endmodule
`default_nettype wire

### rtl/dtr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dtr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/dtr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative divider
// Signed numerator over positive denominator, one quotient bit per cycle,
// truncating toward zero or rounding halves away from zero.
// ----------------------------------------------------------------------------
module dtr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtr_pkg::t_div_req i_req,
    output dtr_pkg::t_div_rsp o_rsp
);
    import dtr_pkg::*;

    localparam int DVD_W = NUM_W + 1;
    localparam int DVS_W = DEN_W + 1;
    localparam int CW    = $clog2(DVD_W);

    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic             r_neg;
    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;

    logic [NUM_W-1:0] mag;
    logic [DVD_W-1:0] n_dvd;
    logic [DVS_W:0]   trial;
    logic             fits;

    always_comb begin
        mag   = i_req.num[NUM_W-1] ? NUM_W'(-i_req.num) : NUM_W'(i_req.num);
        n_dvd = i_req.round ? ({mag, 1'b0} + DVD_W'(i_req.den)) : DVD_W'(mag);
        trial = {r_rem, r_dvd[DVD_W-1]};
        fits  = trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_dvd  <= n_dvd;
                r_dvs  <= i_req.round ? {i_req.den, 1'b0} : {1'b0, i_req.den};
                r_rem  <= '0;
                r_neg  <= i_req.num[NUM_W-1];
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_rem <= fits ? DVS_W'(trial - {1'b0, r_dvs}) : DVS_W'(trial);
                r_dvd <= {r_dvd[DVD_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? t_num'(-r_dvd[NUM_W-1:0]) : t_num'(r_dvd[NUM_W-1:0]);

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-tested triangle rasterizer testbench
// Drives draw, clear, read and no-op requests through the valid/ready
// request channel and checks every response against a local scanline and
// edge-pass model of the depth and colour stores. A directed table comes
// first, then small random triangles with reads aimed at the area just drawn.
// ----------------------------------------------------------------------------
module testbench;
    import dtr_pkg::*;

    localparam int  NUM_ITEMS   = 580;
    localparam int  STALL_LIMIT = 400000;
    localparam int  DRAIN_WAIT  = 200;

    typedef struct {
        t_req        req;
        logic [15:0] x [3];
        logic [15:0] y [3];
        logic [23:0] z [3];
        logic [23:0] colour;
        logic [16:0] pix;
        bit          typed;
        logic [15:0] e_cnt;
        logic [23:0] e_col;
        logic [31:0] e_inv;
    } t_item;

    typedef struct {
        logic [15:0] cnt;
        logic [23:0] col;
        logic [31:0] inv;
    } t_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = REQ_NOP;
    logic signed [15:0] i_v0_x = '0, i_v0_y = '0, i_v1_x = '0;
    logic signed [15:0] i_v1_y = '0, i_v2_x = '0, i_v2_y = '0;
    logic [23:0] i_v0_depth = '0, i_v1_depth = '0, i_v2_depth = '0;
    logic [23:0] i_fill_colour = '0;
    logic [16:0] i_read_pixel_index = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [CNT_W-1:0]   o_pixels_written;
    logic [COL_W-1:0]   o_pixel_colour;
    logic [DEPTH_W-1:0] o_pixel_inverse_depth;

    depth_tested_triangle_rasterizer_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type),
        .i_v0_x(i_v0_x), .i_v0_y(i_v0_y), .i_v0_depth(i_v0_depth),
        .i_v1_x(i_v1_x), .i_v1_y(i_v1_y), .i_v1_depth(i_v1_depth),
        .i_v2_x(i_v2_x), .i_v2_y(i_v2_y), .i_v2_depth(i_v2_depth),
        .i_fill_colour(i_fill_colour), .i_read_pixel_index(i_read_pixel_index),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_pixels_written(o_pixels_written), .o_pixel_colour(o_pixel_colour),
        .o_pixel_inverse_depth(o_pixel_inverse_depth)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [31:0] depth_mem  [NPIX];
    logic [23:0] colour_mem [NPIX];
    logic [23:0] draw_colour;
    int unsigned draw_count;
    t_resp       resp_q [$];
    t_item       table_q [$];
    int          errors = 0;
    int          idle_phase = 0;
    int          last_cx = 20, last_cy = 20;

    function automatic longint round_div(longint num, longint den);
        if (num >= 0) return (2 * num + den) / (2 * den);
        return -((-2 * num + den) / (2 * den));
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void put_pixel(longint px, longint py, longint z);
        logic [31:0] inv;
        int idx;
        if (px < 0 || px >= SCREEN_WIDTH || py < 0 || py >= SCREEN_HEIGHT) return;
        inv = (z <= 0) ? 32'hFFFF_FFFF : 32'(64'hFFFF_FFFF / z);
        idx = int'(py * SCREEN_WIDTH + px);
        if (inv > depth_mem[idx]) begin
            depth_mem[idx]  = inv;
            colour_mem[idx] = draw_colour;
            if (draw_count < 65535) draw_count++;
        end
    endfunction

    function automatic void fill_row(longint py, longint xa, longint za,
                                     longint xb, longint zb);
        longint dx, n;
        dx = xb - xa;
        n  = abs64(dx);
        if (py < 0 || py >= SCREEN_HEIGHT) return;
        for (longint s = 0; s < n; s++)
            put_pixel(xa + (dx > 0 ? s : -s), py, za + (s * (zb - za)) / n);
    endfunction

    function automatic void trace_edge(longint fx, longint fy, longint fz,
                                       longint tx, longint ty, longint tz);
        longint dx, dy, dz, n;
        dx = tx - fx;
        dy = ty - fy;
        dz = tz - fz;
        n  = abs64(dx) > abs64(dy) ? abs64(dx) : abs64(dy);
        for (longint s = 0; 16 * s < n; s++)
            put_pixel(round_div(fx * n + 16 * s * dx, 16 * n),
                      round_div(fy * n + 16 * s * dy, 16 * n),
                      fz + (16 * s * dz) / n);
    endfunction

    function automatic void raster_triangle(longint x [3], longint y [3], longint z [3]);
        int a, b, c;
        longint dx01, dy01, dz01, dx02, dy02, dz02, dx12, dy12, dz12, t, u;
        if (y[0] <= y[1] && y[0] <= y[2]) begin
            a = 0; b = (y[1] <= y[2]) ? 1 : 2; c = 3 - b;
        end else if (y[1] <= y[0] && y[1] <= y[2]) begin
            a = 1; b = (y[0] <= y[2]) ? 0 : 2; c = 2 - b;
        end else begin
            a = 2; b = (y[0] <= y[1]) ? 0 : 1; c = 1 - b;
        end
        dx01 = x[b] - x[a]; dy01 = y[b] - y[a]; dz01 = z[b] - z[a];
        dx02 = x[c] - x[a]; dy02 = y[c] - y[a]; dz02 = z[c] - z[a];
        dx12 = x[c] - x[b]; dy12 = y[c] - y[b]; dz12 = z[c] - z[b];
        for (longint r = 0; 16 * r < dy01; r++) begin
            t = 16 * r;
            fill_row(round_div(y[a] + t, 16),
                     round_div(x[a] * dy02 + t * dx02, 16 * dy02), z[a] + (t * dz02) / dy02,
                     round_div(x[a] * dy01 + t * dx01, 16 * dy01), z[a] + (t * dz01) / dy01);
        end
        for (longint r = 0; 16 * r < dy12; r++) begin
            t = 16 * r;
            u = dy01 + t;
            fill_row(round_div(y[b] + t, 16),
                     round_div(x[a] * dy02 + u * dx02, 16 * dy02), z[a] + (u * dz02) / dy02,
                     round_div(x[b] * dy12 + t * dx12, 16 * dy12), z[b] + (t * dz12) / dy12);
        end
        trace_edge(x[0], y[0], z[0], x[1], y[1], z[1]);
        trace_edge(x[0], y[0], z[0], x[2], y[2], z[2]);
        trace_edge(x[1], y[1], z[1], x[2], y[2], z[2]);
    endfunction

    function automatic t_resp raster_response(t_item it);
        t_resp  rsp;
        longint x [3], y [3], z [3];
        rsp = '{cnt: '0, col: '0, inv: '0};
        case (it.req)
            REQ_DRAW: begin
                for (int v = 0; v < 3; v++) begin
                    x[v] = longint'($signed(it.x[v]));
                    y[v] = longint'($signed(it.y[v]));
                    z[v] = longint'(it.z[v]);
                end
                draw_colour = it.colour;
                draw_count  = 0;
                raster_triangle(x, y, z);
                rsp.cnt = 16'(draw_count);
            end
            REQ_CLEAR: begin
                for (int i = 0; i < NPIX; i++) depth_mem[i] = '0;
            end
            REQ_READ: begin
                if (it.pix < NPIX) begin
                    rsp.col = colour_mem[it.pix];
                    rsp.inv = depth_mem[it.pix];
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, want);
        errors++;
    endtask

    function automatic t_item blank_item(t_req req);
        t_item it;
        it.req = req;
        for (int v = 0; v < 3; v++) begin
            it.x[v] = 16'($urandom);
            it.y[v] = 16'($urandom);
            it.z[v] = 24'($urandom);
        end
        it.colour = 24'($urandom);
        it.pix    = 17'($urandom);
        it.typed  = 1'b0;
        it.e_cnt  = '0;
        it.e_col  = '0;
        it.e_inv  = '0;
        return it;
    endfunction

    function automatic void add_typed(t_req req, logic [16:0] pix);
        t_item it;
        it = blank_item(req);
        it.pix   = pix;
        it.typed = 1'b1;
        table_q.insert(table_q.size(), it);
    endfunction

    function automatic void add_read(int px, int py);
        t_item it;
        it = blank_item(REQ_READ);
        it.pix = 17'(py * SCREEN_WIDTH + px);
        table_q.insert(table_q.size(), it);
    endfunction

    function automatic void add_draw(int x0, int y0, int z0, int x1, int y1, int z1,
                                     int x2, int y2, int z2, int col, bit typed_zero);
        t_item it;
        it = blank_item(REQ_DRAW);
        it.x = '{16'(x0), 16'(x1), 16'(x2)};
        it.y = '{16'(y0), 16'(y1), 16'(y2)};
        it.z = '{24'(z0), 24'(z1), 24'(z2)};
        it.colour = 24'(col);
        it.typed  = typed_zero;
        table_q.insert(table_q.size(), it);
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    sel, dr;
        sel = $urandom_range(0, 999);
        if (sel < 5) return blank_item(REQ_CLEAR);
        if (sel < 25) return blank_item(REQ_NOP);
        if (sel < 420) begin
            it = blank_item(REQ_READ);
            if (sel >= 60)
                it.pix = 17'((last_cy + $urandom_range(0, 8) - 4) * SCREEN_WIDTH
                             + last_cx + $urandom_range(0, 8) - 4);
            if (it.pix >= NPIX && sel >= 60) it.pix = 17'($urandom_range(0, NPIX - 1));
            return it;
        end
        it = blank_item(REQ_DRAW);
        last_cx = $urandom_range(0, 335) - 8;
        last_cy = $urandom_range(0, 255) - 8;
        dr = $urandom_range(0, 1);
        for (int v = 0; v < 3; v++) begin
            it.x[v] = 16'(last_cx * 16 + int'($urandom_range(0, 128)) - 64);
            it.y[v] = 16'(last_cy * 16 + int'($urandom_range(0, 128)) - 64);
            it.z[v] = dr ? 24'($urandom_range(1, 2000)) : 24'($urandom_range(1, 24'hFF_FFFF));
        end
        return it;
    endfunction

    task automatic send_item(t_item it, int gap_pct);
        t_resp want;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_req_type         <= it.req;
        i_v0_x             <= it.x[0];
        i_v0_y             <= it.y[0];
        i_v0_depth         <= it.z[0];
        i_v1_x             <= it.x[1];
        i_v1_y             <= it.y[1];
        i_v1_depth         <= it.z[1];
        i_v2_x             <= it.x[2];
        i_v2_y             <= it.y[2];
        i_v2_depth         <= it.z[2];
        i_fill_colour      <= it.colour;
        i_read_pixel_index <= it.pix;
        do @(posedge i_clk); while (!o_ready);
        want = raster_response(it);
        if (it.typed) want = '{cnt: it.e_cnt, col: it.e_col, inv: it.e_inv};
        resp_q.insert(resp_q.size(), want);
    endtask

    function automatic int sender_gap();
        return idle_phase == 0 ? 27 : (idle_phase == 1 ? 66 : 0);
    endfunction

    function automatic int receiver_gap();
        return idle_phase == 0 ? 66 : (idle_phase == 1 ? 27 : 0);
    endfunction

    int stall_cycles = 0;
    always @(posedge i_clk) begin
        t_resp want;
        if (o_valid && i_ready) begin
            if (resp_q.size() == 0) begin
                report_mismatch("unexpected transfer", o_pixels_written, 0);
            end else begin
                want = resp_q.pop_front();
                if (o_pixels_written !== want.cnt)
                    report_mismatch("pixels_written", o_pixels_written, want.cnt);
                if (o_pixel_colour !== want.col)
                    report_mismatch("pixel_colour", o_pixel_colour, want.col);
                if (o_pixel_inverse_depth !== want.inv)
                    report_mismatch("pixel_inverse_depth", o_pixel_inverse_depth, want.inv);
            end
        end
        i_ready <= ($urandom_range(0, 99) >= receiver_gap());
        if ((o_valid && i_ready) || (i_valid && o_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int sent;
        for (int i = 0; i < NPIX; i++) begin
            depth_mem[i]  = '0;
            colour_mem[i] = '0;
        end
        add_typed(REQ_READ, 17'd0);
        add_typed(REQ_READ, 17'(NPIX - 1));
        add_typed(REQ_READ, 17'h1_FFFF);
        add_typed(REQ_NOP, 17'd5);
        add_typed(REQ_CLEAR, 17'd0);
        add_draw(-32768, -32768, 1, -32768, -32768, 1, -32768, -32768, 1, 0, 1'b1);
        add_draw(32767, 32767, 24'hFF_FFFF, 32767, 32767, 24'hFF_FFFF,
                 32767, 32767, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1);
        add_draw(160, 160, 256, 640, 192, 512, 320, 640, 300, 24'h12_34_56, 1'b0);
        add_draw(160, 160, 4000, 640, 192, 4000, 320, 640, 4000, 24'hAB_CD_EF, 1'b0);
        add_draw(200, 200, 10, 560, 220, 900, 300, 600, 40, 24'h00_FF_00, 1'b0);
        add_read(20, 20);
        add_read(25, 15);
        add_draw(-80, -48, 100, 96, -32, 100, 32, 128, 100, 24'hFF_00_00, 1'b0);
        add_read(0, 0);
        add_draw(5040, 3760, 70, 5200, 3808, 90, 5088, 3920, 60, 24'h00_00_FF, 1'b0);
        add_draw(800, 800, 50, 960, 800, 50, 880, 928, 50, 24'h11_11_11, 1'b0);
        add_draw(800, 1100, 50, 960, 1228, 80, 880, 1228, 20, 24'h22_22_22, 1'b0);
        add_draw(1200, 1200, 0, 1320, 1230, 0, 1250, 1330, 0, 24'h33_33_33, 1'b0);
        add_draw(1608, 1608, 77, 1720, 1640, 33, 1656, 1736, 999, 24'h44_44_44, 1'b0);
        add_read(78, 78);
        add_typed(REQ_CLEAR, 17'd0);
        add_read(20, 20);
        add_read(55, 52);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sent = 0;
        foreach (table_q[k]) begin
            send_item(table_q[k], sender_gap());
            sent++;
        end
        while (sent < NUM_ITEMS) begin
            idle_phase = (sent * 3) / NUM_ITEMS;
            send_item(random_item(), sender_gap());
            sent++;
        end
        i_valid <= 1'b0;
        idle_phase = 2;
        while (resp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
